### hdl/hybrid_merge_insertion_sorter_macros.svh
// Assertion macros used by the checker file of the sorter.
`ifndef HYBRID_MERGE_INSERTION_SORTER_MACROS_SVH
`define HYBRID_MERGE_INSERTION_SORTER_MACROS_SVH

// Checked at every clock edge outside reset.
`define HMS_ASSERT_RST(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// Checked at every clock edge, reset included.
`define HMS_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/hms_pkg.sv
`default_nettype none
package hms_pkg;

    localparam int VALUE_W       = 32;
    localparam int MAX_ITEMS_DEF = 64;

    typedef struct packed {
        logic insert;
        logic shift_out;
    } cmd_t;

    typedef struct packed {
        logic one_left;
    } status_t;

endpackage
`default_nettype wire

### hdl/hms_ctrl.sv
`default_nettype none
module hms_ctrl (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    input  wire logic            s_last,
    output logic                 s_ready,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output logic                 m_last,
    output hms_pkg::cmd_t        cmd,
    input  wire hms_pkg::status_t status
);

    localparam logic ST_LOAD  = 1'b0;
    localparam logic ST_DRAIN = 1'b1;

    logic state_reg;
    logic state_next;

    always_comb begin
        state_next    = state_reg;
        s_ready       = 1'b0;
        m_valid       = 1'b0;
        m_last        = 1'b0;
        cmd.insert    = 1'b0;
        cmd.shift_out = 1'b0;
        case (state_reg)
            ST_LOAD: begin
                s_ready    = 1'b1;
                cmd.insert = s_valid;
                if (s_valid && s_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                m_valid       = 1'b1;
                m_last        = status.one_left;
                cmd.shift_out = m_ready;
                if (m_ready && status.one_left) begin
                    state_next = ST_LOAD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

### hdl/hms_datapath.sv
`default_nettype none
module hms_datapath #(
    parameter int MAX_ITEMS = hms_pkg::MAX_ITEMS_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire hms_pkg::cmd_t               cmd,
    input  wire logic [hms_pkg::VALUE_W-1:0] in_value,
    output hms_pkg::status_t                 status,
    output logic [hms_pkg::VALUE_W-1:0]      out_value,
    output logic                             out_overflow
);

    localparam int CNT_W = $clog2(MAX_ITEMS + 1);

    // The cells hold the list in ascending order; cells at or above the count are unused.
    logic [hms_pkg::VALUE_W-1:0] cell_reg  [MAX_ITEMS];
    logic [hms_pkg::VALUE_W-1:0] cell_next [MAX_ITEMS];
    logic [CNT_W-1:0]            count_reg;
    logic [CNT_W-1:0]            count_next;
    logic                        ovf_reg;
    logic                        ovf_next;
    logic [MAX_ITEMS-1:0]        gt;

    always_comb begin
        for (int i = 0; i < MAX_ITEMS; i++) begin
            gt[i] = (CNT_W'(i) < count_reg) && (cell_reg[i] > in_value);
        end
    end

    always_comb begin
        cell_next  = cell_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (cmd.insert) begin
            if (count_reg < CNT_W'(MAX_ITEMS)) begin
                if (gt[0] || (count_reg == '0)) begin
                    cell_next[0] = in_value;
                end
                for (int i = 1; i < MAX_ITEMS; i++) begin
                    if (gt[i-1]) begin
                        cell_next[i] = cell_reg[i-1];
                    end else if (gt[i] || (CNT_W'(i) == count_reg)) begin
                        cell_next[i] = in_value;
                    end
                end
                count_next = count_reg + CNT_W'(1);
            end else begin
                ovf_next = 1'b1;
            end
        end else if (cmd.shift_out) begin
            for (int i = 0; i < MAX_ITEMS - 1; i++) begin
                cell_next[i] = cell_reg[i+1];
            end
            count_next = count_reg - CNT_W'(1);
            if (count_reg == CNT_W'(1)) begin
                ovf_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cell_reg <= cell_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end else begin
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

    assign status.one_left = (count_reg == CNT_W'(1));
    assign out_value       = cell_reg[0];
    assign out_overflow    = ovf_reg;

endmodule
`default_nettype wire

### hdl/hybrid_merge_insertion_sorter.sv
// While loading, s_ready is held high: each request is inserted into a sorted row of cells.
// The request marked last makes the first result valid in the cycle after it is accepted.
// Results then leave at one per cycle while m_ready is held high.
// Reset (aresetn low at a clock edge) empties the list and clears the overflow flag.
// The cell contents are not cleared by reset.
`default_nettype none
module hybrid_merge_insertion_sorter #(
    parameter int MAX_ITEMS = hms_pkg::MAX_ITEMS_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [hms_pkg::VALUE_W-1:0] s_value,
    input  wire logic                        s_last,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [hms_pkg::VALUE_W-1:0]      m_value,
    output logic                             m_last,
    output logic                             m_overflow
);

    hms_pkg::cmd_t    cmd;
    hms_pkg::status_t status;

    hms_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_last  (s_last),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_last  (m_last),
        .cmd     (cmd),
        .status  (status)
    );

    hms_datapath #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .in_value     (s_value),
        .status       (status),
        .out_value    (m_value),
        .out_overflow (m_overflow)
    );

endmodule
`default_nettype wire

### hdl/hms_checker.sv
`default_nettype none
`include "hybrid_merge_insertion_sorter_macros.svh"
module hms_checker (
    input wire logic                        aclk,
    input wire logic                        aresetn,
    input wire logic                        s_valid,
    input wire logic                        s_ready,
    input wire logic                        s_last,
    input wire logic                        m_valid,
    input wire logic                        m_ready,
    input wire logic [hms_pkg::VALUE_W-1:0] m_value,
    input wire logic                        m_last,
    input wire logic                        m_overflow
);

    `HMS_ASSERT_RST(a_out_hold, aclk, aresetn, (m_valid && !m_ready) |=> (m_valid && $stable(m_value) && $stable(m_last) && $stable(m_overflow)), "stalled result changed")
    `HMS_ASSERT_RST(a_one_side, aclk, aresetn, !(s_ready && m_valid), "load and drain overlap")
    `HMS_ASSERT_RST(a_last_starts, aclk, aresetn, (s_valid && s_ready && s_last) |=> m_valid, "no result after the last request")
    `HMS_ASSERT_RST(a_drain_ends, aclk, aresetn, (m_valid && m_ready && m_last) |=> (!m_valid && s_ready), "block not idle after the final result")
    `HMS_ASSERT_RST(a_ascending, aclk, aresetn, (m_valid && m_ready && !m_last) |=> (m_valid && (m_value >= $past(m_value))), "results out of order")

endmodule

bind hybrid_merge_insertion_sorter hms_checker u_checker (.*);
`default_nettype wire
